FILE: src/assert_macros.svh
// Assertion macros shared by the running median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RMF_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define RMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RMF_ASSERT_ALWAYS(label, clk, rst, expr)
`define RMF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/rmf_pkg.sv
// Shared types for the running median filter.
`default_nettype none
package rmf_pkg;

   // Control passed from each cell to its right-hand neighbor.
   typedef struct packed {
      logic drop_seen;  // the evicted entry sits in this cell or to its left
      logic ins_seen;   // the new sample lands in this cell or to its left
   } link_type;

endpackage
`default_nettype wire

FILE: src/running_median_filter.sv
// Running median filter: a sorted chain of sample cells with age tags.
// An accepted request updates the chain; the median is then registered into the response once that slot is free.
// One request per cycle while the response does not stall; each cell shifts or inserts on an accepted request.
// Reset: window length 1 and an empty window; a window length write also empties it.
// The fill count alone marks which cells hold samples, so no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module running_median_filter #(
   parameter int WINDOW_MAX  = 32,
   parameter int SAMPLE_BITS = 16,
   localparam int CNT_W = $clog2(WINDOW_MAX + 1),
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + CNT_W + 7) / 8) * 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire [REQ_W-1:0]    req_tdata,   // sample
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // median, fill
   input  wire                csr_wr_en,
   input  wire [CNT_W-1:0]    csr_wr_data  // window_len
);

   localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(WINDOW_MAX);

   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [CNT_W-1:0] rsp_fill_ff, rsp_fill_in;

   logic             accept, load_rsp, full;
   logic [CNT_W-1:0] held_after_drop, mid_full;
   logic [AGE_W-1:0] oldest_age, mid_idx;
   logic signed [SAMPLE_BITS-1:0] new_val;

   logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
   logic        [AGE_W-1:0]       cell_age [WINDOW_MAX];
   rmf_pkg::link_type             cell_link [WINDOW_MAX];

   assign new_val         = req_tdata[SAMPLE_BITS-1:0];
   assign full            = (held_ff == len_ff);
   assign held_after_drop = held_ff - CNT_W'(full);
   assign oldest_age      = AGE_W'(len_ff - 1'b1);
   assign mid_full        = held_ff >> 1;
   assign mid_idx         = mid_full[AGE_W-1:0];

   // The median is picked from the updated chain as soon as the response register is free.
   assign load_rsp   = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || load_rsp;
   assign accept     = req_tvalid && req_tready;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] l_val, r_val;
      logic        [AGE_W-1:0]       l_age, r_age;
      rmf_pkg::link_type             l_link;
      if (i == 0) begin : g_first
         assign l_val  = '0;
         assign l_age  = '0;
         assign l_link = '0;
      end else begin : g_mid
         assign l_val  = cell_val[i-1];
         assign l_age  = cell_age[i-1];
         assign l_link = cell_link[i-1];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
         assign r_val = '0;
         assign r_age = '0;
      end else begin : g_inner
         assign r_val = cell_val[i+1];
         assign r_age = cell_age[i+1];
      end
      rmf_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .AGE_W      (AGE_W),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock          (clock),
         .shift_en       (accept),
         .new_val        (new_val),
         .full           (full),
         .oldest_age     (oldest_age),
         .held           (held_ff),
         .held_after_drop(held_after_drop),
         .left_val       (l_val),
         .left_age       (l_age),
         .left_link      (l_link),
         .right_val      (r_val),
         .right_age      (r_age),
         .val            (cell_val[i]),
         .age            (cell_age[i]),
         .link_out       (cell_link[i])
      );
   end

   always_comb begin
      len_in        = len_ff;
      held_in       = held_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = cell_val[mid_idx];
         rsp_fill_in   = held_ff;
         pend_in       = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
         held_in = full ? held_ff : CNT_W'(held_ff + 1'b1);
      end
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = CNT_W'(1);
         end else if (csr_wr_data > LEN_MAX) begin
            len_in = LEN_MAX;
         end else begin
            len_in = csr_wr_data;
         end
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= CNT_W'(1);
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_fill_ff, rsp_median_ff});

   `RMF_ASSERT_ALWAYS(a_held_in_window, clock, reset, (len_ff != '0) && (held_ff <= len_ff))
   `RMF_ASSERT_NEXT(a_held_steps, clock, reset, accept && !csr_wr_en, held_ff == CNT_W'($past(held_ff) + CNT_W'(!$past(full))))
   `RMF_ASSERT_IMPL(a_stall_only_when_blocked, clock, reset, !req_tready, pend_ff && rsp_valid_ff && !rsp_tready)

endmodule
`default_nettype wire

FILE: src/rmf_cell.sv
// One cell of the sorted window chain: holds one sample and its age.
`default_nettype none
module rmf_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int AGE_W       = 5,
   parameter int CNT_W       = 6,
   parameter int INDEX       = 0
) (
   input  wire                          clock,
   input  wire                          shift_en,
   input  wire signed [SAMPLE_BITS-1:0] new_val,
   input  wire                          full,
   input  wire        [AGE_W-1:0]       oldest_age,
   input  wire        [CNT_W-1:0]       held,
   input  wire        [CNT_W-1:0]       held_after_drop,
   input  wire signed [SAMPLE_BITS-1:0] left_val,
   input  wire        [AGE_W-1:0]       left_age,
   input  rmf_pkg::link_type            left_link,
   input  wire signed [SAMPLE_BITS-1:0] right_val,
   input  wire        [AGE_W-1:0]       right_age,
   output logic signed [SAMPLE_BITS-1:0] val,
   output logic        [AGE_W-1:0]       age,
   output rmf_pkg::link_type            link_out
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   logic        [AGE_W-1:0]       age_ff, age_in;
   logic                          occupied, drop_here, drop_seen;
   logic signed [SAMPLE_BITS-1:0] own_val, prev_val;
   logic        [AGE_W-1:0]       own_age, prev_age;
   logic                          occupied_after, ins_seen;

   always_comb begin
      occupied  = IDX < held;
      drop_here = full && occupied && (age_ff == oldest_age);
      drop_seen = left_link.drop_seen || drop_here;
      // Contents of this slot and the slot to the left once the evicted entry is gone.
      own_val   = drop_seen ? right_val : val_ff;
      own_age   = drop_seen ? right_age : age_ff;
      prev_val  = left_link.drop_seen ? val_ff : left_val;
      prev_age  = left_link.drop_seen ? age_ff : left_age;
      occupied_after = IDX < held_after_drop;
      ins_seen  = !occupied_after || (own_val > new_val);
      if (left_link.ins_seen) begin
         val_in = prev_val;
         age_in = AGE_W'(prev_age + 1'b1);
      end else if (ins_seen) begin
         val_in = new_val;
         age_in = '0;
      end else begin
         val_in = own_val;
         age_in = AGE_W'(own_age + 1'b1);
      end
      link_out.drop_seen = drop_seen;
      link_out.ins_seen  = ins_seen;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule
`default_nettype wire

FILE: tb/sv/running_median_checker.sv
// Checker for the running median filter: predicts each median and compares responses.
`default_nettype none
module running_median_checker #(
   parameter int WINDOW_MAX = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire [15:0]  req_tdata,    // sample
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire [23:0]  rsp_tdata,    // median, fill
   input  wire         csr_wr_en,
   input  wire [5:0]   csr_wr_data,  // window_len
   output int          fail_count,
   output int          expected_left
);

   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [15:0] median;
      logic [5:0]  fill;
   } median_result_type;

   median_result_type   medians_due[$];
   median_result_type   got_result;
   median_result_type   due_result;
   logic signed [15:0]  ring [WINDOW_MAX];
   int                  write_slot;
   int                  held;
   int                  window_len;

   task automatic report_mismatch(input string what);
      fail_count++;
      // Keep the log short when the block is badly broken; every failure still counts.
      if (fail_count <= MAX_PRINTED) begin
         $display("%0t: median filter mismatch: %s", $time, what);
      end
   endtask

   task automatic clear_ring();
      for (int i = 0; i < WINDOW_MAX; i++) begin
         ring[i] = '0;
      end
      write_slot = 0;
      held       = 0;
   endtask

   // Sorts a copy of the held samples and picks the upper of the middle values.
   function automatic logic [15:0] upper_median();
      logic signed [15:0] sorted [WINDOW_MAX];
      logic signed [15:0] key;
      int                 i;
      int                 j;
      for (i = 0; i < held; i++) begin
         sorted[i] = ring[i];
      end
      for (i = 1; i < held; i++) begin
         key = sorted[i];
         j   = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return sorted[held / 2];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_ring();
         window_len = 1;
         fail_count = 0;
         medians_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data > WINDOW_MAX) begin
               window_len = WINDOW_MAX;
            end else if (csr_wr_data == 0) begin
               window_len = 1;
            end else begin
               window_len = csr_wr_data;
            end
            clear_ring();
         end
         if (req_tvalid && req_tready) begin
            if (write_slot >= window_len) begin
               write_slot = 0;
            end
            ring[write_slot] = req_tdata;
            write_slot = (write_slot + 1 == window_len) ? 0 : write_slot + 1;
            if (held < window_len) begin
               held++;
            end
            due_result.median = upper_median();
            due_result.fill   = 6'(held);
            medians_due.push_back(due_result);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_result.median = rsp_tdata[15:0];
            got_result.fill   = rsp_tdata[21:16];
            if (medians_due.size() == 0) begin
               report_mismatch($sformatf("response (median %0d, fill %0d) with no request open",
                  $signed(got_result.median), got_result.fill));
            end else begin
               due_result = medians_due.pop_front();
               if (got_result.median !== due_result.median) begin
                  report_mismatch($sformatf("median %0d, predicted %0d",
                     $signed(got_result.median), $signed(due_result.median)));
               end
               if (got_result.fill !== due_result.fill) begin
                  report_mismatch($sformatf("fill %0d, predicted %0d",
                     got_result.fill, due_result.fill));
               end
            end
         end
      end
      expected_left = medians_due.size();
   end

endmodule
`default_nettype wire

FILE: tb/sv/running_median_filter_tb.sv
// Testbench top for the running median filter: stimulus, handshake pacing and verdict.
`default_nettype none
module running_median_filter_tb;

   localparam int RANDOM_ITEMS = 1425;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int SETTLE       = 4;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;
   logic         csr_wr_en;
   logic [5:0]   csr_wr_data;

   int           fail_count;
   int           expected_left;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           stall_cycles;
   logic [15:0]  last_sample;

   running_median_filter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   running_median_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Ends the run when neither channel nor the register port moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic push_sample(input logic [15:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // The window length may only change once every median has come back.
   task automatic set_window(input logic [5:0] value);
      req_tvalid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of wide random values, clustered values with many ties, extremes and ramps.
   function automatic logic [15:0] next_sample();
      logic [15:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = 16'($urandom);
         4, 5, 6:    value = 16'(int'($urandom_range(0, 8)) - 4);
         7: begin
            case ($urandom_range(0, 3))
               0:       value = 16'h8000;
               1:       value = 16'h7fff;
               2:       value = 16'h0000;
               default: value = 16'hffff;
            endcase
         end
         8:       value = last_sample + 16'd257;
         default: value = last_sample + 16'(int'($urandom_range(0, 6)) - 3);
      endcase
      last_sample = value;
      return value;
   endfunction

   function automatic logic [5:0] pick_window();
      case ($urandom_range(0, 9))
         0:       return 6'd1;
         1:       return 6'd2;
         2:       return 6'd3;
         3:       return 6'd32;
         4:       return 6'd31;
         5:       return 6'($urandom_range(33, 63));
         6:       return 6'd0;
         default: return 6'($urandom_range(1, 32));
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      int phase;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      last_sample   = '0;
      send_idle_pct = 31;
      recv_idle_pct = 48;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Window length of one straight out of reset.
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h0000);

      // A zero length is taken as one.
      set_window(6'd0);
      push_sample(16'hffff);
      push_sample(16'h0001);

      // An all-ones length is clamped to the largest window; start-up with ties.
      set_window(6'd63);
      push_sample(16'h8000);
      push_sample(16'h7fff);
      push_sample(16'h7fff);
      push_sample(16'h0000);
      push_sample(16'h8000);
      push_sample(16'h5555);
      push_sample(16'haaaa);
      push_sample(16'hffff);

      // Even fill gives the upper middle value; the third sample evicts the first.
      set_window(6'd2);
      push_sample(16'd7);
      push_sample(-16'sd7);
      push_sample(16'd100);

      set_window(6'd33);
      push_sample(16'h0001);

      set_window(6'd3);
      push_sample(16'd5);
      push_sample(16'd5);
      push_sample(-16'sd3);
      push_sample(16'd9);
      push_sample(16'd9);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         set_window(pick_window());
         burst = $urandom_range(8, 90);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            phase = sent * 3 / RANDOM_ITEMS;
            case (phase)
               0: begin
                  send_idle_pct = 31;
                  recv_idle_pct = 48;
               end
               1: begin
                  send_idle_pct = 48;
                  recv_idle_pct = 31;
               end
               default: begin
                  send_idle_pct = 0;
                  recv_idle_pct = 0;
               end
            endcase
            push_sample(next_sample());
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/rmf_pkg.sv
src/rmf_cell.sv
src/running_median_filter.sv
tb/sv/running_median_checker.sv
tb/sv/running_median_filter_tb.sv
